@@ design/bir_pkg.sv @@
// Shared types and constants for the bilinear RGB resize block.
package bir_pkg;

    localparam int COORD_W    = 12;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int FRAC_W     = 8;
    localparam int WGT_W      = 17;
    localparam int ACC_W      = 24;
    localparam int SRC_CFG_W  = 9;
    localparam int DST_CFG_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int RATIO_FRAC = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_SAVE,
        S_MUL,
        S_AXIS,
        S_READ,
        S_LAST
    } t_state;

    typedef struct packed {
        logic       in_accept;
        logic       div_load;
        logic       div_axis;
        logic       div_step;
        logic       ratio_save;
        logic       mul_en;
        logic       axis_en;
        logic       read_en;
        logic [1:0] nbr;
        logic       acc_clr;
        logic       acc_en;
        logic       out_load;
    } t_cmd;

endpackage

@@ design/bilinear_image_resize_rgb.sv @@
// Top level of the bilinear RGB resize block over a frame store.
// o_out_valid rises once an accepted pixel request has passed the multiply, axis, four
// read and last states; the last state waits while a stalled far side holds the result.
// Source pixel writes stream at one per cycle while the block is idle and its ratios current.
// A new request is accepted only after the previous one is done with the position stages,
// the four neighbor reads through the single read port of the frame store and the blend.
// After reset and after any configuration write the step ratios are rebuilt by a
// one-bit-per-cycle divider, x axis then y axis, with the input stalled.
module bilinear_image_resize_rgb #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bir_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bir_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bir_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bir_pkg::*;

    // The divider produces one quotient bit per cycle; its width covers the
    // largest (source size - 1) shifted up by the 16 fraction bits.
    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT);
    localparam int SM1_W = (XW > YW) ? XW : YW;
    localparam int QUO_W = SM1_W + RATIO_FRAC;

    t_cmd      cmd;
    t_out_item out_item;
    logic      out_valid;

    // The controller sequences each transaction. A source pixel write goes
    // straight into the frame store. A pixel request walks through the position
    // multiply, the clamp of the integer part and fraction, four neighbor reads
    // with their weights, and the per-channel accumulation. The finished pixel
    // sits in the output register until the far side takes it; new source
    // writes are accepted meanwhile.
    bir_ctrl #(
        .QUO_W (QUO_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_item.op),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .o_in_stall  (o_in_stall),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Configuration registers, the ratio divider, the frame store and the
    // blend arithmetic all live in the datapath. Its output register is
    // loaded on the same edge that raises the controller's valid flag.
    bir_datapath #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_DIM    (MAX_DST_DIM)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_item (out_item)
    );

    assign o_out_item  = out_item;
    assign o_out_valid = out_valid;

endmodule

@@ design/bir_datapath.sv @@
// Datapath of the resize block: configuration, ratio divider, frame store and blend.
module bir_datapath #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bir_pkg::t_cmd                    i_cmd,
    input  bir_pkg::t_in_item                i_in_item,
    input  logic                             i_cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bir_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bir_pkg::t_out_item               o_out_item
);
    import bir_pkg::*;

    localparam int XW     = $clog2(MAX_SRC_WIDTH);
    localparam int YW     = $clog2(MAX_SRC_HEIGHT);
    localparam int SW_W   = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SH_W   = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DW_W   = $clog2(MAX_DST_DIM + 1);
    localparam int SM1_W  = (XW > YW) ? XW : YW;
    localparam int QUO_W  = SM1_W + RATIO_FRAC;
    localparam int POS_W  = COORD_W + QUO_W;
    localparam int IP_W   = POS_W - RATIO_FRAC;
    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW     = $clog2(DEPTH);

    // Configuration registers.
    logic [SRC_CFG_W-1:0] r_src_width;
    logic [SRC_CFG_W-1:0] r_src_height;
    logic [DST_CFG_W-1:0] r_dst_width;
    logic [DST_CFG_W-1:0] r_dst_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_CFG_W'(256);
            r_src_height <= SRC_CFG_W'(256);
            r_dst_width  <= DST_CFG_W'(256);
            r_dst_height <= DST_CFG_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SRC_CFG_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[SRC_CFG_W-1:0];
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[DST_CFG_W-1:0];
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[DST_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero counts as one, anything above the maximum saturates.
    logic [SW_W-1:0] sw_eff;
    logic [SH_W-1:0] sh_eff;
    logic [DW_W-1:0] dw_eff;
    logic [DW_W-1:0] dh_eff;
    logic [XW-1:0]   sm1_x;
    logic [YW-1:0]   sm1_y;

    always_comb begin
        if (r_src_width == '0) begin
            sw_eff = SW_W'(1);
        end else if (32'(r_src_width) > MAX_SRC_WIDTH) begin
            sw_eff = SW_W'(MAX_SRC_WIDTH);
        end else begin
            sw_eff = SW_W'(r_src_width);
        end
        if (r_src_height == '0) begin
            sh_eff = SH_W'(1);
        end else if (32'(r_src_height) > MAX_SRC_HEIGHT) begin
            sh_eff = SH_W'(MAX_SRC_HEIGHT);
        end else begin
            sh_eff = SH_W'(r_src_height);
        end
        if (r_dst_width == '0) begin
            dw_eff = DW_W'(1);
        end else if (32'(r_dst_width) > MAX_DST_DIM) begin
            dw_eff = DW_W'(MAX_DST_DIM);
        end else begin
            dw_eff = DW_W'(r_dst_width);
        end
        if (r_dst_height == '0) begin
            dh_eff = DW_W'(1);
        end else if (32'(r_dst_height) > MAX_DST_DIM) begin
            dh_eff = DW_W'(MAX_DST_DIM);
        end else begin
            dh_eff = DW_W'(r_dst_height);
        end
        sm1_x = XW'(sw_eff - SW_W'(1));
        sm1_y = YW'(sh_eff - SH_W'(1));
    end

    // Restoring divider, one quotient bit per step: ratio = ((src-1) << 16) / dst.
    logic [QUO_W-1:0] r_quo;
    logic [DW_W-1:0]  r_rem;
    logic [DW_W-1:0]  r_div_d;
    logic [QUO_W-1:0] r_ratio_x;
    logic [QUO_W-1:0] r_ratio_y;
    logic [DW_W:0]    div_trial;
    logic             div_bit;
    logic [DW_W-1:0]  div_rem;

    always_comb begin
        div_trial = {r_rem, r_quo[QUO_W-1]};
        div_bit   = (div_trial >= {1'b0, r_div_d});
        if (div_bit) begin
            div_rem = DW_W'(div_trial - {1'b0, r_div_d});
        end else begin
            div_rem = div_trial[DW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= '0;
            if (i_cmd.div_axis == AXIS_Y) begin
                r_div_d <= dh_eff;
                r_quo   <= {SM1_W'(sm1_y), RATIO_FRAC'(0)};
            end else begin
                r_div_d <= dw_eff;
                r_quo   <= {SM1_W'(sm1_x), RATIO_FRAC'(0)};
            end
        end else if (i_cmd.div_step) begin
            r_rem <= div_rem;
            r_quo <= {r_quo[QUO_W-2:0], div_bit};
        end
        if (i_cmd.ratio_save) begin
            if (i_cmd.div_axis == AXIS_Y) begin
                r_ratio_y <= r_quo;
            end else begin
                r_ratio_x <= r_quo;
            end
        end
    end

    // Frame store: written by source pixel transactions, read once per neighbor.
    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [XW-1:0]    rd_x;
    logic [YW-1:0]    rd_y;
    logic [XW-1:0]    r_x0;
    logic [XW-1:0]    r_x1;
    logic [YW-1:0]    r_y0;
    logic [YW-1:0]    r_y1;

    always_comb begin
        wr_en = i_cmd.in_accept && (i_in_item.op == OP_WRITE)
             && (32'(i_in_item.col) < MAX_SRC_WIDTH)
             && (32'(i_in_item.row) < MAX_SRC_HEIGHT);
        wr_addr = AW'(32'(i_in_item.row) * MAX_SRC_WIDTH + 32'(i_in_item.col));
        rd_x    = i_cmd.nbr[0] ? r_x1 : r_x0;
        rd_y    = i_cmd.nbr[1] ? r_y1 : r_y0;
        rd_addr = AW'(32'(rd_y) * MAX_SRC_WIDTH + 32'(rd_x));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {i_in_item.red_in, i_in_item.green_in, i_in_item.blue_in};
        end
        if (i_cmd.read_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Source position along both axes.
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [POS_W-1:0]   r_pos_x;
    logic [POS_W-1:0]   r_pos_y;
    logic [FRAC_W-1:0]  r_fx;
    logic [FRAC_W-1:0]  r_fy;
    logic [IP_W-1:0]    ip_x;
    logic [IP_W-1:0]    ip_y;
    logic [XW-1:0]      x0;
    logic [YW-1:0]      y0;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;

    always_comb begin
        ip_x = r_pos_x[POS_W-1:RATIO_FRAC];
        ip_y = r_pos_y[POS_W-1:RATIO_FRAC];
        // Past the last column or row the position saturates and loses its fraction.
        if (ip_x > IP_W'(sm1_x)) begin
            x0 = sm1_x;
            fx = '0;
        end else begin
            x0 = XW'(ip_x);
            fx = r_pos_x[RATIO_FRAC-1:RATIO_FRAC-FRAC_W];
        end
        if (ip_y > IP_W'(sm1_y)) begin
            y0 = sm1_y;
            fy = '0;
        end else begin
            y0 = YW'(ip_y);
            fy = r_pos_y[RATIO_FRAC-1:RATIO_FRAC-FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_accept) begin
            r_col <= i_in_item.col;
            r_row <= i_in_item.row;
        end
        if (i_cmd.mul_en) begin
            r_pos_x <= POS_W'(r_col) * POS_W'(r_ratio_x);
            r_pos_y <= POS_W'(r_row) * POS_W'(r_ratio_y);
        end
        if (i_cmd.axis_en) begin
            r_x0 <= x0;
            r_y0 <= y0;
            r_x1 <= (x0 < sm1_x) ? XW'(x0 + XW'(1)) : sm1_x;
            r_y1 <= (y0 < sm1_y) ? YW'(y0 + YW'(1)) : sm1_y;
            r_fx <= fx;
            r_fy <= fy;
        end
    end

    // Weight of each neighbor, registered alongside its read data.
    logic [FRAC_W:0]  wx;
    logic [FRAC_W:0]  wy;
    logic [WGT_W-1:0] w_prod;
    logic [WGT_W-1:0] r_wgt;

    always_comb begin
        wx     = i_cmd.nbr[0] ? {1'b0, r_fx} : (9'd256 - {1'b0, r_fx});
        wy     = i_cmd.nbr[1] ? {1'b0, r_fy} : (9'd256 - {1'b0, r_fy});
        w_prod = WGT_W'(wx) * WGT_W'(wy);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_en) begin
            r_wgt <= w_prod;
        end
    end

    // Per-channel accumulation of pixel times weight. The output register
    // takes the running sum plus the last product, so it holds the top CHAN_W bits of the full sum.
    logic [ACC_W-1:0] r_acc   [3];
    logic [ACC_W-1:0] prod    [3];
    logic [ACC_W-1:0] acc_sum [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c]    = ACC_W'(25'(r_rd_data[CHAN_W*(2-c) +: CHAN_W]) * 25'(r_wgt));
            acc_sum[c] = r_acc[c] + prod[c];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.acc_clr) begin
                r_acc[c] <= '0;
            end else if (i_cmd.acc_en) begin
                r_acc[c] <= acc_sum[c];
            end
        end
        if (i_cmd.out_load) begin
            o_out_item.red_out   <= acc_sum[0][ACC_W-1:ACC_W-CHAN_W];
            o_out_item.green_out <= acc_sum[1][ACC_W-1:ACC_W-CHAN_W];
            o_out_item.blue_out  <= acc_sum[2][ACC_W-1:ACC_W-CHAN_W];
        end
    end

endmodule

@@ design/bir_ctrl.sv @@
// Controller state machine of the resize block.
module bir_ctrl #(
    parameter int QUO_W = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    input  logic          i_out_stall,
    input  logic          i_cfg_we,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output bir_pkg::t_cmd o_cmd
);
    import bir_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_nbr, n_nbr;
    logic             r_axis, n_axis;
    logic             r_dirty, n_dirty;
    logic             r_out_valid, n_out_valid;
    logic             ready;
    logic             accept;
    logic             out_free;

    assign ready    = (r_state == S_IDLE) && !r_dirty;
    assign accept   = ready && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_nbr       <= '0;
            r_axis      <= AXIS_X;
            r_dirty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_nbr       <= n_nbr;
            r_axis      <= n_axis;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_nbr       = r_nbr;
        n_axis      = r_axis;
        n_dirty     = r_dirty || i_cfg_we;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (r_dirty) begin
                    n_state = S_DIV_LOAD;
                    n_axis  = AXIS_X;
                    n_dirty = i_cfg_we;
                end else if (accept && (i_in_op == OP_REQUEST)) begin
                    n_state = S_MUL;
                end
            end
            S_DIV_LOAD: begin
                n_state = S_DIV_RUN;
                n_cnt   = CNT_W'(QUO_W - 1);
            end
            S_DIV_RUN: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_DIV_SAVE;
                end
            end
            S_DIV_SAVE: begin
                if (r_axis == AXIS_X) begin
                    n_axis  = AXIS_Y;
                    n_state = S_DIV_LOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_AXIS;
            end
            S_AXIS: begin
                n_state = S_READ;
                n_nbr   = '0;
            end
            S_READ: begin
                n_nbr = r_nbr + 2'd1;
                if (r_nbr == 2'd3) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.in_accept  = accept;
        o_cmd.div_axis   = r_axis;
        o_cmd.nbr        = r_nbr;
        o_in_stall       = !ready;
        o_out_valid      = r_out_valid;
        case (r_state)
            S_DIV_LOAD: o_cmd.div_load   = 1'b1;
            S_DIV_RUN:  o_cmd.div_step   = 1'b1;
            S_DIV_SAVE: o_cmd.ratio_save = 1'b1;
            S_MUL:      o_cmd.mul_en     = 1'b1;
            S_AXIS: begin
                o_cmd.axis_en = 1'b1;
                o_cmd.acc_clr = 1'b1;
            end
            S_READ: begin
                o_cmd.read_en = 1'b1;
                o_cmd.acc_en  = (r_nbr != 2'd0);
            end
            S_LAST: begin
                // The output register takes the sum including the last neighbor
                // on the edge that raises the valid flag.
                o_cmd.acc_en   = out_free;
                o_cmd.out_load = out_free;
            end
            default: ;
        endcase
    end

endmodule
